### src/bmp_to_framebuffer_blit_macros.svh
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit assertion macros
// Concurrent assertion wrappers used by the bfb_parse module.
// ----------------------------------------------------------------------------
`ifndef BMP_TO_FRAMEBUFFER_BLIT_MACROS_SVH
`define BMP_TO_FRAMEBUFFER_BLIT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge out of reset
`define BFB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("bfb assertion failed");

// antecedent implies consequent in the next cycle
`define BFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bfb assertion failed");

`else

`define BFB_ASSERT(lbl, clk, rstn, prop)
`define BFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### src/bfb_pkg.sv
// ----------------------------------------------------------------------------
// bfb_pkg
// Constants and types of the BMP to framebuffer blitter.
// ----------------------------------------------------------------------------
package bfb_pkg;

  localparam int FB_WIDTH_DEF  = 640;
  localparam int FB_HEIGHT_DEF = 480;

  localparam int HDR_POS_W = 6;
  localparam logic [HDR_POS_W-1:0] HEADER_BYTES = 6'd54;

  // header byte positions of the low 16 bits of width and height
  localparam logic [HDR_POS_W-1:0] HDR_WIDTH_LO  = 6'd18;
  localparam logic [HDR_POS_W-1:0] HDR_WIDTH_HI  = 6'd19;
  localparam logic [HDR_POS_W-1:0] HDR_HEIGHT_LO = 6'd22;
  localparam logic [HDR_POS_W-1:0] HDR_HEIGHT_HI = 6'd23;

  localparam int DIM_W     = 16;
  localparam int ROW_REG_W = 9;
  localparam int COL_REG_W = 10;
  localparam int ADDR_W    = 19;
  localparam int PIX_W     = 24;
  // covers framebuffer sides up to 4096
  localparam int COORD_W   = 12;

  // byte phase within a pixel
  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  // configuration register indexes
  localparam logic REG_START_ROW = 1'b0;
  localparam logic REG_START_COL = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   color;
    logic               last;
  } pix_t;

endpackage

### src/bfb_parse.sv
// ----------------------------------------------------------------------------
// bfb_parse
// Byte parser: header fields, pixel grouping, padding skip, row/col tracking.
// ----------------------------------------------------------------------------
`include "bmp_to_framebuffer_blit_macros.svh"

module bfb_parse import bfb_pkg::*; #(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ROW_REG_W-1:0] start_row_i,
  input  logic [COL_REG_W-1:0] start_col_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 image_start_i,
  output logic                 pix_valid_o,
  output pix_t                 pix_o,
  input  logic                 pix_ready_i
);

  logic [HDR_POS_W-1:0] hdr_pos_q, hdr_pos_d;
  logic [DIM_W-1:0]     width_q, width_d;
  logic [DIM_W-1:0]     height_q, height_d;
  logic [DIM_W-1:0]     col_cnt_q, col_cnt_d;
  logic [DIM_W-1:0]     row_cnt_q, row_cnt_d;
  logic [1:0]           phase_q, phase_d;
  logic [1:0]           pad_q, pad_d;
  logic [7:0]           blue_q, blue_d;
  logic [7:0]           green_q, green_d;
  logic                 done_q, done_d;
  logic                 pix_valid_q, pix_valid_d;
  pix_t                 pix_q, pix_d;
  logic                 accept;
  logic                 emit;

  assign in_ready_o  = !pix_valid_q || pix_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

  always_comb begin
    logic [HDR_POS_W-1:0] pos_w;
    logic [DIM_W-1:0]     w_w, h_w, col_w, row_w, row_off;
    logic [1:0]           phase_w, pad_w;
    logic                 done_w;
    logic [DIM_W:0]       row_full, col_full, col_next, row_next;
    logic                 last;

    hdr_pos_d = hdr_pos_q;
    width_d   = width_q;
    height_d  = height_q;
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    phase_d   = phase_q;
    pad_d     = pad_q;
    blue_d    = blue_q;
    green_d   = green_q;
    done_d    = done_q;
    pix_d     = pix_q;
    emit      = 1'b0;

    // start marker wipes the image in progress
    pos_w   = image_start_i ? '0 : hdr_pos_q;
    w_w     = image_start_i ? '0 : width_q;
    h_w     = image_start_i ? '0 : height_q;
    col_w   = image_start_i ? '0 : col_cnt_q;
    row_w   = image_start_i ? '0 : row_cnt_q;
    phase_w = image_start_i ? PH_BLUE : phase_q;
    pad_w   = image_start_i ? '0 : pad_q;
    done_w  = image_start_i ? 1'b0 : done_q;

    row_off  = h_w - DIM_W'(1) - row_w;
    row_full = (DIM_W+1)'(start_row_i) + (DIM_W+1)'(row_off);
    col_full = (DIM_W+1)'(start_col_i) + (DIM_W+1)'(col_w);
    col_next = (DIM_W+1)'(col_w) + (DIM_W+1)'(1);
    row_next = (DIM_W+1)'(row_w) + (DIM_W+1)'(1);
    last     = (row_next == (DIM_W+1)'(h_w)) && (col_next == (DIM_W+1)'(w_w));

    if (accept) begin
      hdr_pos_d = pos_w;
      width_d   = w_w;
      height_d  = h_w;
      col_cnt_d = col_w;
      row_cnt_d = row_w;
      phase_d   = phase_w;
      pad_d     = pad_w;
      done_d    = done_w;
      if (!done_w) begin
        if (pos_w < HEADER_BYTES) begin
          case (pos_w)
            HDR_WIDTH_LO:  width_d[7:0]   = data_byte_i;
            HDR_WIDTH_HI:  width_d[15:8]  = data_byte_i;
            HDR_HEIGHT_LO: height_d[7:0]  = data_byte_i;
            HDR_HEIGHT_HI: height_d[15:8] = data_byte_i;
            default: ;
          endcase
          hdr_pos_d = pos_w + HDR_POS_W'(1);
          // empty image ends at the close of the header
          if ((hdr_pos_d == HEADER_BYTES) && (width_d == '0 || height_d == '0)) begin
            done_d = 1'b1;
          end
        end else if (pad_w != '0) begin
          pad_d = pad_w - 2'd1;
        end else begin
          case (phase_w)
            PH_BLUE: begin
              blue_d  = data_byte_i;
              phase_d = PH_GREEN;
            end
            PH_GREEN: begin
              green_d = data_byte_i;
              phase_d = PH_RED;
            end
            default: begin
              phase_d = PH_BLUE;
              emit = (row_full < (DIM_W+1)'(FB_HEIGHT)) &&
                     (col_full < (DIM_W+1)'(FB_WIDTH));
              pix_d.row   = row_full[COORD_W-1:0];
              pix_d.col   = col_full[COORD_W-1:0];
              pix_d.color = {blue_q, green_q, data_byte_i};
              pix_d.last  = last;
              if (col_next >= (DIM_W+1)'(w_w)) begin
                if (row_next >= (DIM_W+1)'(h_w)) begin
                  done_d    = 1'b1;
                  col_cnt_d = col_next[DIM_W-1:0];
                end else begin
                  row_cnt_d = row_next[DIM_W-1:0];
                  col_cnt_d = '0;
                  pad_d     = w_w[1:0];
                end
              end else begin
                col_cnt_d = col_next[DIM_W-1:0];
              end
            end
          endcase
        end
      end
    end

    if (accept) begin
      pix_valid_d = emit;
    end else begin
      pix_valid_d = pix_valid_q && !pix_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= '0;
      width_q     <= '0;
      height_q    <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      phase_q     <= PH_BLUE;
      pad_q       <= '0;
      done_q      <= 1'b1;
      pix_valid_q <= 1'b0;
    end else begin
      hdr_pos_q   <= hdr_pos_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      phase_q     <= phase_d;
      pad_q       <= pad_d;
      done_q      <= done_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
    pix_q   <= pix_d;
  end

  `BFB_ASSERT(a_hdr_pos_range, clk_i, rst_ni, hdr_pos_q <= HEADER_BYTES)
  `BFB_ASSERT(a_counts_in_image, clk_i, rst_ni,
              (done_q || hdr_pos_q != HEADER_BYTES) ||
              (col_cnt_q < width_q && row_cnt_q < height_q))
  `BFB_ASSERT_NEXT(a_no_pix_while_idle, clk_i, rst_ni,
                   done_q && !(in_valid_i && image_start_i) && !pix_valid_q,
                   !pix_valid_q)

endmodule

### src/bfb_addr.sv
// ----------------------------------------------------------------------------
// bfb_addr
// Output stage: framebuffer word address and result register.
// ----------------------------------------------------------------------------
module bfb_addr import bfb_pkg::*; #(
  parameter int FB_WIDTH = FB_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  pix_t              pix_i,
  output logic              pix_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] fb_address_o,
  output logic [PIX_W-1:0]  pixel_word_o,
  output logic              last_pixel_o
);

  logic              out_valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [PIX_W-1:0]  word_q;
  logic              last_q;
  logic              load;
  logic [31:0]       addr_full;

  assign pix_ready_o = !out_valid_q || out_ready_i;
  assign load        = pix_valid_i && pix_ready_o;
  assign addr_full   = 32'(pix_i.row) * 32'(FB_WIDTH) + 32'(pix_i.col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= addr_full[ADDR_W-1:0];
      word_q <= pix_i.color;
      last_q <= pix_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fb_address_o = addr_q;
  assign pixel_word_o = word_q;
  assign last_pixel_o = last_q;

endmodule

### src/bmp_to_framebuffer_blit.sv
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit
// 24-bit bottom-up BMP byte stream to framebuffer pixel writes.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  ---------+-----------+------------------------------------------------
//  in       | sink      | in_valid_i/in_ready_o, data_byte_i, image_start_i
//  out      | source    | out_valid_o/out_ready_i, fb_address_o,
//           |           | pixel_word_o, last_pixel_o
//  apb      | slave     | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one byte per cycle while in_ready_o is high; after its red byte a pixel write
// passes the parser register, then address multiply into the output register
// header and padding bytes produce no transaction
// out stall: the parser register and the output register hold one pixel each
// reset leaves the parser idle until a byte with image_start_i set
// ----------------------------------------------------------------------------
module bmp_to_framebuffer_blit import bfb_pkg::*; #(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              image_start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] fb_address_o,
  output logic [PIX_W-1:0]  pixel_word_o,
  output logic              last_pixel_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [ROW_REG_W-1:0] start_row_q;
  logic [COL_REG_W-1:0] start_col_q;
  logic                 reg_wr;
  logic                 reg_idx;
  logic                 pix_valid;
  logic                 pix_ready;
  pix_t                 pix;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q <= '0;
      start_col_q <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_START_ROW: start_row_q <= pwdata[ROW_REG_W-1:0];
        REG_START_COL: start_col_q <= pwdata[COL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_ROW: prdata = 32'(start_row_q);
      REG_START_COL: prdata = 32'(start_col_q);
      default:       prdata = '0;
    endcase
  end

  bfb_parse #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_row_i   (start_row_q),
    .start_col_i   (start_col_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .image_start_i (image_start_i),
    .pix_valid_o   (pix_valid),
    .pix_o         (pix),
    .pix_ready_i   (pix_ready)
  );

  bfb_addr #(
    .FB_WIDTH (FB_WIDTH)
  ) u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (pix_valid),
    .pix_i        (pix),
    .pix_ready_o  (pix_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fb_address_o (fb_address_o),
    .pixel_word_o (pixel_word_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
